[rtl/bsu_pkg.sv]
package bsu_pkg;

    // Width of one list element.
    localparam int WORD_W = 32;

    // One signed list element, two's complement.
    typedef logic signed [WORD_W-1:0] t_word;

    // Sort direction register: 1 ascending, any negative pattern descending,
    // 0 keeps the input order.
    typedef logic signed [1:0] t_dir;

    localparam t_dir DIR_ASCENDING = 2'sd1;
    localparam t_dir DIR_KEEP      = 2'sd0;

endpackage

[rtl/bsu_in_if.sv]
// Input channel: one list element and its end-of-list mark.
interface bsu_in_if;
    logic              valid;
    logic              ready;
    bsu_pkg::t_word    number_in;
    logic              list_end;

    modport source (output valid, output number_in, output list_end, input ready);
    modport sink   (input valid, input number_in, input list_end, output ready);
endinterface

[rtl/bsu_out_if.sv]
// Output channel: one sorted element with its final and overflow marks.
interface bsu_out_if;
    logic              valid;
    logic              ready;
    bsu_pkg::t_word    number_out;
    logic              final_out;
    logic              overflow_out;

    modport source (output valid, output number_out, output final_out,
                    output overflow_out, input ready);
    modport sink   (input valid, input number_out, input final_out,
                    input overflow_out, output ready);
endinterface

[rtl/bsu_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module bsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[rtl/bidirectional_bubble_sorter_unit.sv]
// Bubble sorter for lists of signed 32-bit words. Words arrive one per
// handshake on the input channel; the word marked list_end closes the list.
// Up to LIST_DEPTH words are kept in a single RAM; further words of the same
// list are dropped and every result of that list then carries overflow_out.
// After the list closes, the RAM is sorted in place by repeated bubble passes
// and the words leave in order on the output channel, the last one marked
// with final_out. The sort_direction register selects ascending (1),
// descending (any negative value) or input order (0); write it only while
// the block is idle. For a list of n stored words, a sort pass streams the
// RAM once through its single read port, and n - 1 passes are run (none
// when n < 2 or the direction is 0). The output is read back one word at a
// time, and each word waits for the sink to take it. No new list is taken
// until the final word has been delivered.
module bidirectional_bubble_sorter_unit #(
    parameter int LIST_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  bsu_pkg::t_dir i_cfg_wr_data,
    bsu_in_if.sink        i_in,
    bsu_out_if.source     o_out
);

    import bsu_pkg::*;

    // Address width of the store and width of a count that can hold the depth.
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_TAIL,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_SEND
    } t_state;

    t_state          r_state;
    t_dir            r_dir;
    logic [CW-1:0]   r_count;
    logic            r_dropped;

    // Sort pass bookkeeping.
    logic [CW-1:0]   r_rd_idx;
    logic            r_pend;
    logic [AW-1:0]   r_pend_idx;
    logic [CW-1:0]   r_pass;
    t_word           r_carry;

    // Output side.
    logic [CW-1:0]   r_out_idx;
    logic            r_out_valid;
    t_word           r_out_word;
    logic            r_final;
    logic            r_overflow;

    // RAM ports.
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    t_word           w_wr_data;
    logic [AW-1:0]   w_rd_addr;
    t_word           w_rd_data;

    logic            w_in_acc;
    logic            w_full;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   w_last;
    logic            w_swap;
    logic            w_keep;

    bsu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign i_in.ready         = (r_state == ST_LOAD);
    assign w_in_acc           = i_in.valid && i_in.ready;
    assign w_full             = (r_count == CW'(LIST_DEPTH));
    assign n_count            = w_full ? r_count : r_count + CW'(1);
    assign w_last             = r_count - CW'(1);
    assign w_keep             = (r_dir == DIR_KEEP);

    // The carry register holds the element that bubbles along the pass. The
    // element just read back is compared with it; a strict compare keeps
    // equal values in input order. Bit 1 of the direction is its sign.
    assign w_swap = r_dir[1] ? (r_carry < w_rd_data) : (r_carry > w_rd_data);

    assign o_out.valid        = r_out_valid;
    assign o_out.number_out   = r_out_word;
    assign o_out.final_out    = r_final;
    assign o_out.overflow_out = r_overflow;

    // RAM port selection. Loading appends at the fill count; a sort pass
    // writes the lesser (or greater) element one slot behind the word just
    // read, and the tail cycle parks the carried element in the last slot.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = i_in.number_in;
        w_rd_addr = r_out_idx[AW-1:0];
        unique case (r_state)
            ST_LOAD: begin
                w_wr_en = w_in_acc && !w_full;
            end
            ST_SORT: begin
                w_rd_addr = r_rd_idx[AW-1:0];
                w_wr_en   = r_pend && (r_pend_idx != '0);
                w_wr_addr = r_pend_idx - AW'(1);
                w_wr_data = w_swap ? w_rd_data : r_carry;
            end
            ST_TAIL: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_last[AW-1:0];
                w_wr_data = r_carry;
            end
            ST_OUT_RD, ST_OUT_LD, ST_OUT_SEND: begin
                w_rd_addr = r_out_idx[AW-1:0];
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dir       <= DIR_ASCENDING;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_pass      <= '0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dir <= i_cfg_wr_data;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        r_count <= n_count;
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_in.list_end) begin
                            r_rd_idx  <= '0;
                            r_pend    <= 1'b0;
                            r_pass    <= '0;
                            r_out_idx <= '0;
                            if (w_keep || (n_count < CW'(2))) begin
                                r_state <= ST_OUT_RD;
                            end else begin
                                r_state <= ST_SORT;
                            end
                        end
                    end
                end
                ST_SORT: begin
                    // Issue reads in address order; the read data is registered in the RAM.
                    r_pend     <= (r_rd_idx < r_count);
                    r_pend_idx <= r_rd_idx[AW-1:0];
                    if (r_rd_idx < r_count) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (r_pend) begin
                        if (r_pend_idx == '0) begin
                            r_carry <= w_rd_data;
                        end else begin
                            r_carry <= w_swap ? r_carry : w_rd_data;
                        end
                        if (r_pend_idx == w_last[AW-1:0]) begin
                            r_state <= ST_TAIL;
                        end
                    end
                end
                ST_TAIL: begin
                    r_pend   <= 1'b0;
                    r_rd_idx <= '0;
                    r_pass   <= r_pass + CW'(1);
                    if (r_pass + CW'(1) == w_last) begin
                        r_state <= ST_OUT_RD;
                    end else begin
                        r_state <= ST_SORT;
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    r_out_word  <= w_rd_data;
                    r_final     <= (r_out_idx == w_last);
                    r_overflow  <= r_dropped;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT_SEND;
                end
                ST_OUT_SEND: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_final) begin
                            // List done: the next list starts empty.
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= ST_LOAD;
                        end else begin
                            r_out_idx <= r_out_idx + CW'(1);
                            r_state   <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

[rtl/bsu_checker.sv]
// Port-level checks for the bubble sorter.
module bsu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_in_list_end,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input bsu_pkg::t_word i_out_number,
    input logic           i_out_final,
    input logic           i_out_overflow
);

    import bsu_pkg::*;

    // Loading and delivery never overlap.
    a_no_load_while_sending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready)
    ) else $error("input ready while an output word is pending");

    // Accepting the word that closes a list withdraws input ready.
    a_close_stops_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_list_end) |=> !i_in_ready
    ) else $error("input still ready after list end");

    // Delivering the final word ends the burst.
    a_final_ends_burst: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_final) |=> !i_out_valid
    ) else $error("output valid right after final word");

    // A stalled output word holds its payload.
    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_number) && $stable(i_out_final)
             && $stable(i_out_overflow))
    ) else $error("stalled output word changed");

endmodule

bind bidirectional_bubble_sorter_unit bsu_checker u_bsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_list_end  (i_in.list_end),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_number   (o_out.number_out),
    .i_out_final    (o_out.final_out),
    .i_out_overflow (o_out.overflow_out)
);

[bench/tb_bidirectional_bubble_sorter_unit.sv]
// Testbench for the bidirectional bubble sorter.
//
// Lists of signed words go in on the input channel. Each list is closed by
// the word that carries list_end. A predictor inside this bench keeps its own
// copy of the list and of the direction register. When a list closes, the
// predictor sorts its copy and queues one expected word per stored element.
// A checker process compares every word that leaves the block, field by
// field, with the oldest queued expectation.
//
// The run steps through directed lists, a capacity test and four random
// traffic phases. The direction register is only written when the block is
// idle. The sender and the receiver both idle or stall at rates that change
// from phase to phase.
module tb_bidirectional_bubble_sorter_unit;
    import bsu_pkg::*;

    // The instance is built with the full depth so that the overflow path
    // can be reached with lists of modest length.
    localparam int CAPACITY = 64;

    // Descending order can be selected by either negative pattern of the
    // two-bit register, so both of them get a name of their own.
    localparam t_dir DIR_DESCENDING = 2'sb11;
    localparam t_dir DIR_DESC_ALT   = 2'sb10;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // After its final word the block returns to idle; the bench waits out
    // this settling time before it writes the register.
    localparam int SETTLE_CYCLES = 8;

    // The slowest correct run stays far below this limit. A full list costs
    // the most sort time, and each output word also waits out the stall time
    // of the receiver.
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    // One expected output word.
    typedef struct {
        t_word number;
        logic  last_mark;
        logic  dropped_mark;
    } t_sorted_word;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    t_dir  cfg_wr_data = DIR_ASCENDING;
    logic  src_valid   = 1'b0;
    t_word src_word    = '0;
    logic  src_last    = 1'b0;
    logic  sink_ready  = 1'b0;

    bsu_in_if  in_ch();
    bsu_out_if out_ch();

    // The bench drives the channel inputs through its own variables. In this
    // way every input has a known value from time zero.
    assign in_ch.valid     = src_valid;
    assign in_ch.number_in = src_word;
    assign in_ch.list_end  = src_last;
    assign out_ch.ready    = sink_ready;

    bidirectional_bubble_sorter_unit #(
        .LIST_DEPTH(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_ch),
        .o_out        (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // This is the state of the predictor. It holds the list gathered so far,
    // the drop flag and the direction that the block should be using.
    t_word        held_words[$];
    bit           held_dropped = 1'b0;
    t_dir         sort_dir     = DIR_ASCENDING;
    t_sorted_word sorted_expected[$];

    // These are the idle and stall rates in percent. The main sequence sets
    // them at the start of each phase.
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned cycle_count     = 0;
    int unsigned error_count     = 0;
    int unsigned words_sent      = 0;
    int unsigned lists_sent      = 0;
    int unsigned overflow_lists  = 0;
    int unsigned results_checked = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still expected.",
                     cycle_count, sorted_expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver draws a new ready value on every edge. At a stall rate of
    // zero it never holds the block back.
    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic void note_error(string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    // Every word accepted on the output channel is checked against the
    // oldest expectation. A word that arrives with nothing queued is an error.
    always @(posedge i_clk) begin : result_check
        t_sorted_word want;
        if (i_rst_n && out_ch.valid && sink_ready) begin
            results_checked++;
            if (sorted_expected.size() == 0) begin
                note_error($sformatf("unexpected word %0d final=%0b overflow=%0b",
                                     out_ch.number_out, out_ch.final_out,
                                     out_ch.overflow_out));
            end else begin
                want = sorted_expected.pop_front();
                if (out_ch.number_out !== want.number
                        || out_ch.final_out !== want.last_mark
                        || out_ch.overflow_out !== want.dropped_mark) begin
                    note_error($sformatf(
                        "expected %0d final=%0b overflow=%0b, got %0d final=%0b overflow=%0b",
                        want.number, want.last_mark, want.dropped_mark,
                        out_ch.number_out, out_ch.final_out, out_ch.overflow_out));
                end
            end
        end
    end

    // The predictor takes in one accepted word. A word that finds the list
    // full is dropped, and the list remembers the drop. When the closing word
    // arrives, the list is bubble-sorted with a strict compare, so equal
    // values keep their input order. One expectation is then queued for each
    // stored word.
    task automatic predict_word(t_word v, bit last);
        t_sorted_word item;
        t_word        a;
        t_word        b;
        int unsigned  n;
        bit           swap;
        if (held_words.size() < CAPACITY) begin
            held_words.push_back(v);
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            n = held_words.size();
            if (sort_dir != DIR_KEEP) begin
                for (int unsigned pass = 0; pass + 1 < n; pass++) begin
                    for (int unsigned k = 1; k < n; k++) begin
                        a = held_words[k-1];
                        b = held_words[k];
                        swap = (sort_dir > DIR_KEEP) ? (a > b) : (a < b);
                        if (swap) begin
                            held_words[k-1] = b;
                            held_words[k]   = a;
                        end
                    end
                end
            end
            for (int unsigned k = 0; k < n; k++) begin
                item.number       = held_words[k];
                item.last_mark    = (k + 1 == n);
                item.dropped_mark = held_dropped;
                sorted_expected.push_back(item);
            end
            if (held_dropped) begin
                overflow_lists++;
            end
            lists_sent++;
            held_words.delete();
            held_dropped = 1'b0;
        end
    endtask

    // This task sends one word. Before it offers the word, the sender may sit
    // idle first. The valid signal stays high after a handshake. The next call
    // or the drain task then sets it in the same time step, so each step sees
    // only one assignment to it.
    task automatic send_word(t_word v, bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge i_clk);
        end
        src_valid <= 1'b1;
        src_word  <= v;
        src_last  <= last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        words_sent++;
        predict_word(v, last);
    endtask

    // This task lowers valid and waits until every expected word has come
    // out. It then lets the block settle back to idle.
    task automatic wait_drained();
        src_valid <= 1'b0;
        while (sorted_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The direction register is only written while the block is idle.
    task automatic set_direction(t_dir dir);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sort_dir = dir;
    endtask

    // Random values lean toward the extremes and toward a narrow band around
    // zero, so that equal values and sign changes show up often. The rest
    // covers the whole 32-bit range.
    function automatic t_word pick_value();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end else if (mode <= 3) begin
            return t_word'(int'($urandom_range(0, 15)) - 8);
        end
        return t_word'($urandom);
    endfunction

    task automatic send_random_list(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_word(pick_value(), k + 1 == n);
        end
    endtask

    // This test keeps the reset direction, which is ascending. Both ends of
    // the range appear twice, next to zero and minus one.
    task automatic test_value_extremes();
        t_word vals[7];
        vals = '{WORD_MAX, WORD_MIN, 0, -1, 1, WORD_MIN, WORD_MAX};
        foreach (vals[k]) begin
            send_word(vals[k], k == 6);
        end
        wait_drained();
    endtask

    // A list of one word is closed by that same word. It must come out
    // alone, carrying final_out.
    task automatic test_single_word();
        send_word(42, 1'b1);
        wait_drained();
    endtask

    // The same short list is sent under every register setting. One setting
    // is the pattern 2'b10, which the block must read as descending.
    task automatic test_directions();
        t_dir  dirs[4];
        t_word vals[4];
        dirs = '{DIR_DESCENDING, DIR_KEEP, DIR_DESC_ALT, DIR_ASCENDING};
        vals = '{5, -3, 5, WORD_MIN};
        foreach (dirs[d]) begin
            set_direction(dirs[d]);
            foreach (vals[k]) begin
                send_word(vals[k], k == 3);
            end
        end
        wait_drained();
    endtask

    // The first list fills the store exactly. The second list is two words
    // too long, and the dropped words include the one that closes the list.
    // Every result of the second list must carry overflow_out.
    task automatic test_capacity();
        set_direction(DIR_ASCENDING);
        send_random_list(CAPACITY);
        set_direction(DIR_DESCENDING);
        send_random_list(CAPACITY + 2);
        wait_drained();
    endtask

    // One random phase sends lists until it has used its word budget. Most
    // lists are short. A few are mid-sized. After the second list the sender
    // holds off until the block has delivered everything.
    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                    t_dir dir, int unsigned budget);
        int unsigned used;
        int unsigned n;
        int unsigned lists;
        used  = 0;
        lists = 0;
        set_direction(dir);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        while (used < budget) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                             : $urandom_range(1, 12);
            send_random_list(n);
            used += n;
            lists++;
            if (lists == 2) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // There are four phases: no idling, a mostly idle sender, a mostly
    // stalled receiver, and both sides idling now and then. Each phase runs
    // under its own direction setting.
    task automatic test_random_traffic();
        run_random_phase(0,  0,  DIR_ASCENDING,  40);
        run_random_phase(81, 0,  DIR_DESCENDING, 40);
        run_random_phase(0,  81, DIR_KEEP,       40);
        run_random_phase(29, 29, DIR_DESC_ALT,   40);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_extremes();
        test_single_word();
        test_directions();
        test_capacity();
        test_random_traffic();

        wait_drained();
        $display("Sent %0d words in %0d lists, %0d of them over capacity; checked %0d results.",
                 words_sent, lists_sent, overflow_lists, results_checked);
        $display("Covered all four direction patterns, extreme values and idle/stall mixes.");
        if (error_count == 0 && sorted_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words never delivered.",
                     error_count, sorted_expected.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
